// ----- design/message_dedup_cache_macros.svh -----
// Assertion macros used by the scan design file.
// Each macro expects signals named clk and rst in the module that uses it.
`ifndef MESSAGE_DEDUP_CACHE_MACROS_SVH
`define MESSAGE_DEDUP_CACHE_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define MDC_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, checked outside reset.
`define MDC_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- design/mdc_pkg.sv -----
`timescale 1ns / 1ps

package mdc_pkg;

  // Table geometry.
  localparam int SLOT_COUNT = 64;
  localparam int IDX_W      = (SLOT_COUNT > 1) ? $clog2(SLOT_COUNT) : 1;
  localparam int CNT_W      = $clog2(SLOT_COUNT + 1);

  // Lifetime register reset value in milliseconds.
  localparam logic [31:0] LIFETIME_RESET = 32'd30000;

  // Depth of the request queue between front and back.
  localparam int QUEUE_DEPTH = 2;
  localparam int QPTR_W      = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
  localparam int QCNT_W      = $clog2(QUEUE_DEPTH + 1);

  // One lookup request.
  typedef struct packed {
    logic [63:0] sender;
    logic [63:0] msg_time;
    logic [7:0]  msg_kind;
    logic [63:0] now_time;
  } item_t;

  // One stored table entry.
  typedef struct packed {
    logic [63:0] added_time;
    logic [63:0] sender;
    logic [63:0] msg_time;
    logic [7:0]  kind;
  } slot_t;

  localparam int SLOT_W = $bits(slot_t);

  // Back-end sequencer states.
  typedef enum logic [1:0] {
    S_IDLE,
    S_SCAN,
    S_INSERT,
    S_REPORT
  } scan_state_t;

endpackage

// ----- design/mdc_ram.sv -----
`timescale 1ns / 1ps

module mdc_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port, one read port with registered data.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

// ----- design/mdc_front.sv -----
`timescale 1ns / 1ps

module mdc_front (
  input  logic          clk,
  input  logic          rst,
  input  logic          in_valid,
  output logic          in_ready,
  input  mdc_pkg::item_t in_item,
  output logic          q_valid,
  output mdc_pkg::item_t q_item,
  input  logic          q_pop
);
  import mdc_pkg::*;

  item_t             slots [QUEUE_DEPTH];
  logic [QPTR_W-1:0] wr_ptr;
  logic [QPTR_W-1:0] rd_ptr;
  logic [QCNT_W-1:0] count;
  logic              push;
  logic              pop;

  // The queue takes an item whenever it has room.
  assign in_ready = (count != QCNT_W'(QUEUE_DEPTH));
  assign push     = in_valid && in_ready;
  assign q_valid  = (count != '0);
  assign pop      = q_pop && q_valid;
  assign q_item   = slots[rd_ptr];

  // Pointers and fill count.
  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
      count  <= '0;
    end else begin
      if (push) begin
        wr_ptr <= (wr_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : wr_ptr + 1'b1;
      end
      if (pop) begin
        rd_ptr <= (rd_ptr == QPTR_W'(QUEUE_DEPTH - 1)) ? '0 : rd_ptr + 1'b1;
      end
      if (push && !pop) begin
        count <= count + 1'b1;
      end else if (pop && !push) begin
        count <= count - 1'b1;
      end
    end
  end

  // Queue storage.
  always_ff @(posedge clk) begin
    if (push) begin
      slots[wr_ptr] <= in_item;
    end
  end

endmodule

// ----- design/mdc_scan.sv -----
`timescale 1ns / 1ps

`include "message_dedup_cache_macros.svh"

module mdc_scan (
  input  logic           clk,
  input  logic           rst,
  input  logic           cfg_we,
  input  logic [31:0]    cfg_wdata,
  input  logic           q_valid,
  input  mdc_pkg::item_t q_item,
  output logic           q_pop,
  output logic           out_valid,
  input  logic           out_ready,
  output logic           already_seen
);
  import mdc_pkg::*;

  scan_state_t           state;
  scan_state_t           state_next;
  item_t                 cur;
  logic [CNT_W-1:0]      rd_cnt;
  logic                  ev_vld;
  logic [IDX_W-1:0]      ev_idx;
  logic [SLOT_COUNT-1:0] slot_valid;
  logic                  have_free;
  logic [IDX_W-1:0]      free_idx;
  logic                  have_old;
  logic [IDX_W-1:0]      old_idx;
  logic [63:0]           old_time;
  logic                  seen;
  logic [31:0]           lifetime;
  logic                  res_valid;
  logic                  res_seen;

  logic                  ram_we;
  logic                  ram_re;
  logic [IDX_W-1:0]      dst_idx;
  slot_t                 wr_ent;
  logic [SLOT_W-1:0]     ram_rdata;
  slot_t                 ent;
  logic [64:0]           age;
  logic                  ent_live;
  logic                  ent_exp;
  logic                  key_eq;
  logic                  scan_hit;
  logic                  scan_end;
  logic                  issue;
  logic                  res_free;
  logic                  res_load;

  // Slot table storage.
  mdc_ram #(
    .WIDTH (SLOT_W),
    .DEPTH (SLOT_COUNT)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .waddr (dst_idx),
    .wdata (wr_ent),
    .re    (ram_re),
    .raddr (rd_cnt[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  // Classification of the entry that came back from the table.
  always_comb begin
    ent      = slot_t'(ram_rdata);
    age      = {1'b0, cur.now_time} - {1'b0, ent.added_time};
    ent_live = slot_valid[ev_idx];
    ent_exp  = ent_live && !age[64] && (age[63:0] > {32'd0, lifetime});
    key_eq   = (ent.kind == cur.msg_kind) && (ent.msg_time == cur.msg_time)
               && (ent.sender == cur.sender);
    scan_hit = ev_vld && ent_live && !ent_exp && key_eq;
    scan_end = ev_vld && !scan_hit && (ev_idx == IDX_W'(SLOT_COUNT - 1));
    res_free = !res_valid || out_ready;
    dst_idx  = have_free ? free_idx : old_idx;
    wr_ent   = '{added_time: cur.now_time, sender: cur.sender,
                 msg_time: cur.msg_time, kind: cur.msg_kind};
  end

  // Next state.
  always_comb begin
    state_next = state;
    unique case (state)
      S_IDLE: begin
        if (q_valid) begin
          state_next = S_SCAN;
        end
      end
      S_SCAN: begin
        if (scan_hit) begin
          state_next = S_REPORT;
        end else if (scan_end) begin
          state_next = S_INSERT;
        end
      end
      S_INSERT: begin
        state_next = S_REPORT;
      end
      S_REPORT: begin
        if (res_free) begin
          state_next = S_IDLE;
        end
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // Sequencer outputs.
  always_comb begin
    q_pop    = 1'b0;
    issue    = 1'b0;
    ram_we   = 1'b0;
    res_load = 1'b0;
    unique case (state)
      S_IDLE: begin
        q_pop = q_valid;
      end
      S_SCAN: begin
        issue = (rd_cnt < CNT_W'(SLOT_COUNT));
      end
      S_INSERT: begin
        ram_we = 1'b1;
      end
      S_REPORT: begin
        res_load = res_free;
      end
      default: begin
        q_pop = 1'b0;
      end
    endcase
    ram_re = issue;
  end

  assign out_valid    = res_valid;
  assign already_seen = res_seen;

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      state      <= S_IDLE;
      ev_vld     <= 1'b0;
      slot_valid <= '0;
      lifetime   <= LIFETIME_RESET;
      res_valid  <= 1'b0;
    end else begin
      state  <= state_next;
      ev_vld <= issue && !scan_hit;
      if (cfg_we) begin
        lifetime <= cfg_wdata;
      end
      if (res_load) begin
        res_valid <= 1'b1;
      end else if (out_ready) begin
        res_valid <= 1'b0;
      end
      // Expired entries are freed as the scan passes them.
      if (state == S_SCAN && ev_vld && ent_exp) begin
        slot_valid[ev_idx] <= 1'b0;
      end
      if (ram_we) begin
        slot_valid[dst_idx] <= 1'b1;
      end
    end
  end

  // Job and scan bookkeeping.
  always_ff @(posedge clk) begin
    ev_idx <= rd_cnt[IDX_W-1:0];
    if (res_load) begin
      res_seen <= seen;
    end
    if (state == S_IDLE && q_valid) begin
      cur       <= q_item;
      rd_cnt    <= '0;
      have_free <= 1'b0;
      have_old  <= 1'b0;
      seen      <= 1'b0;
    end
    if (issue) begin
      rd_cnt <= rd_cnt + 1'b1;
    end
    if (state == S_SCAN && ev_vld) begin
      if (!ent_live || ent_exp) begin
        // First free or freed slot is the insert target.
        if (!have_free) begin
          have_free <= 1'b1;
          free_idx  <= ev_idx;
        end
      end else if (key_eq) begin
        seen <= 1'b1;
      end else if (!have_old || ent.added_time < old_time) begin
        // Oldest live slot, lowest index on ties.
        have_old <= 1'b1;
        old_idx  <= ev_idx;
        old_time <= ent.added_time;
      end
    end
  end

  `MDC_ASSERT_IMP(a_write_only_insert, ram_we, state == S_INSERT, "table write outside insert")
  `MDC_ASSERT_IMP(a_eval_in_scan, ev_vld, state == S_SCAN, "entry evaluated outside scan")
  `MDC_ASSERT_NXT(a_insert_then_report, state == S_INSERT, state == S_REPORT, "insert not followed by report")
  `MDC_ASSERT_IMP(a_insert_target, ram_we, have_free || have_old, "insert without a target slot")

endmodule

// ----- design/message_dedup_cache.sv -----
`timescale 1ns / 1ps

// Channel   Handshake              Payload
// input     in_valid / in_ready    sender, msg_time, msg_kind, now_time
// result    out_valid / out_ready  already_seen
// config    cfg_we                 cfg_wdata (lifetime_ms)
//
// An item leaves the queue, then the slots are read in order from a table
// with one write port and a registered read port; on a miss the item is
// inserted, and the result is handed over at the report step.
// A hit ends the scan early at the matching slot.
// Reset clears all valid marks at once; no clearing pass is needed.
// A two-item queue takes input while the scan runs; a waiting result holds
// the scan at its report step.
module message_dedup_cache (
  input  logic        clk,
  input  logic        rst,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic [63:0] sender,
  input  logic [63:0] msg_time,
  input  logic [7:0]  msg_kind,
  input  logic [63:0] now_time,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        already_seen,
  input  logic        cfg_we,
  input  logic [31:0] cfg_wdata
);
  import mdc_pkg::*;

  item_t in_item;
  item_t q_item;
  logic  q_valid;
  logic  q_pop;

  assign in_item = '{sender: sender, msg_time: msg_time, msg_kind: msg_kind,
                     now_time: now_time};

  // Front: request queue.
  mdc_front u_front (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .in_item  (in_item),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop)
  );

  // Back: table scan, insert and result register.
  mdc_scan u_scan (
    .clk          (clk),
    .rst          (rst),
    .cfg_we       (cfg_we),
    .cfg_wdata    (cfg_wdata),
    .q_valid      (q_valid),
    .q_item       (q_item),
    .q_pop        (q_pop),
    .out_valid    (out_valid),
    .out_ready    (out_ready),
    .already_seen (already_seen)
  );

endmodule

// ----- bench/tb_message_dedup_cache.sv -----
`timescale 1ns / 1ps

module tb_message_dedup_cache;
  import mdc_pkg::item_t;

  localparam int STALL_LIMIT = 5000;
  localparam int DRAIN_CYCLES = 80;
  localparam int RECENT_KEEP = 48;
  localparam int BATCH_ITEMS = 110;

  // Lifetime regimes used by the random traffic.
  typedef enum int {
    LIFE_SHORT,
    LIFE_DEFAULT,
    LIFE_FOREVER,
    LIFE_ZERO,
    LIFE_RANDOM
  } life_regime_t;

  logic        clk = 1'b0;
  logic        rst;
  logic        in_valid;
  logic        in_ready;
  logic [63:0] sender;
  logic [63:0] msg_time;
  logic [7:0]  msg_kind;
  logic [63:0] now_time;
  logic        out_valid;
  logic        out_ready;
  logic        already_seen;
  logic        cfg_we;
  logic [31:0] cfg_wdata;

  // Shadow copy of the cache table and the lifetime register.
  bit          slot_live [mdc_pkg::SLOT_COUNT];
  logic [63:0] slot_born [mdc_pkg::SLOT_COUNT];
  logic [63:0] slot_sender [mdc_pkg::SLOT_COUNT];
  logic [63:0] slot_mtime [mdc_pkg::SLOT_COUNT];
  logic [7:0]  slot_kind [mdc_pkg::SLOT_COUNT];
  logic [31:0] life_ms;

  bit     pending_seen[$];
  item_t  recent_keys[$];
  logic [63:0] clock_ms;
  int     in_idle_pct;
  int     out_idle_pct;
  int     error_count;
  int     result_count;
  int     stall_cycles;
  logic   want_seen;

  message_dedup_cache DUT (
    .clk(clk),
    .rst(rst),
    .in_valid(in_valid),
    .in_ready(in_ready),
    .sender(sender),
    .msg_time(msg_time),
    .msg_kind(msg_kind),
    .now_time(now_time),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .already_seen(already_seen),
    .cfg_we(cfg_we),
    .cfg_wdata(cfg_wdata)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Scan the shadow table for one key, freeing expired slots on the way,
  // and insert the key when no live copy is found. Returns the seen flag.
  function automatic bit dedup_lookup(input item_t it);
    bit          have_free;
    int          free_idx;
    bit          have_old;
    int          old_idx;
    logic [63:0] old_born;
    int          dst;
    have_free = 1'b0;
    free_idx = 0;
    have_old = 1'b0;
    old_idx = 0;
    old_born = '0;
    for (int i = 0; i < mdc_pkg::SLOT_COUNT; i++) begin
      if (!slot_live[i]) begin
        if (!have_free) begin
          have_free = 1'b1;
          free_idx = i;
        end
      end else if (it.now_time > slot_born[i] &&
                   (it.now_time - slot_born[i]) > {32'd0, life_ms}) begin
        // Expired entries are dropped even if the scan later hits.
        slot_live[i] = 1'b0;
        if (!have_free) begin
          have_free = 1'b1;
          free_idx = i;
        end
      end else if (slot_kind[i] == it.msg_kind && slot_mtime[i] == it.msg_time &&
                   slot_sender[i] == it.sender) begin
        return 1'b1;
      end else if (!have_old || slot_born[i] < old_born) begin
        have_old = 1'b1;
        old_idx = i;
        old_born = slot_born[i];
      end
    end
    dst = have_free ? free_idx : old_idx;
    slot_live[dst] = 1'b1;
    slot_born[dst] = it.now_time;
    slot_sender[dst] = it.sender;
    slot_mtime[dst] = it.msg_time;
    slot_kind[dst] = it.msg_kind;
    return 1'b0;
  endfunction

  // Receiver side: random back-pressure on the result channel.
  always @(negedge clk) begin
    out_ready <= ($urandom_range(0, 99) >= out_idle_pct);
  end

  // Result checking, prediction of accepted items and the stall watchdog.
  always @(posedge clk) begin
    if (!rst) begin
      if (out_valid && out_ready) begin
        result_count++;
        if (pending_seen.size() == 0) begin
          error_count++;
          if (error_count <= 10)
            $display("%0t: result %0d arrived with nothing pending, already_seen=%0b",
                     $realtime, result_count, already_seen);
        end else begin
          want_seen = pending_seen.pop_front();
          if (already_seen !== want_seen) begin
            error_count++;
            if (error_count <= 10)
              $display("%0t: result %0d already_seen expected %0b actual %0b",
                       $realtime, result_count, want_seen, already_seen);
          end
        end
      end
      if (in_valid && in_ready)
        pending_seen.push_back(dedup_lookup('{sender, msg_time, msg_kind, now_time}));
      if (cfg_we)
        life_ms = cfg_wdata;
      if ((in_valid && in_ready) || (out_valid && out_ready)) begin
        stall_cycles = 0;
      end else begin
        stall_cycles++;
        if (stall_cycles >= STALL_LIMIT) begin
          $display("tb_message_dedup_cache: errors");
          $finish;
        end
      end
    end
  end

  // Present one item and hold it until the block takes it. Valid drops at
  // a falling edge only: while the sender idles or before the input waits.
  task automatic send_item(input item_t it);
    @(negedge clk);
    while ($urandom_range(0, 99) < in_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    sender <= it.sender;
    msg_time <= it.msg_time;
    msg_kind <= it.msg_kind;
    now_time <= it.now_time;
    in_valid <= 1'b1;
    do
      @(posedge clk);
    while (!in_ready);
  endtask

  task automatic send_key(input logic [63:0] snd, input logic [63:0] mt,
                          input logic [7:0] kind, input logic [63:0] now);
    item_t it;
    it.sender = snd;
    it.msg_time = mt;
    it.msg_kind = kind;
    it.now_time = now;
    send_item(it);
  endtask

  // Wait until every result is back and the scan has surely finished.
  task automatic wait_drained();
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_seen.size() != 0)
      @(posedge clk);
    repeat (8) @(posedge clk);
  endtask

  task automatic write_lifetime(input logic [31:0] value);
    wait_drained();
    @(negedge clk);
    cfg_wdata <= value;
    cfg_we <= 1'b1;
    @(negedge clk);
    cfg_we <= 1'b0;
  endtask

  function automatic item_t random_key();
    item_t it;
    it.sender = {$urandom, $urandom};
    it.msg_time = {$urandom, $urandom};
    it.msg_kind = $urandom_range(0, 255);
    it.now_time = '0;
    return it;
  endfunction

  task automatic remember_key(input item_t it);
    recent_keys.push_back(it);
    if (recent_keys.size() > RECENT_KEEP)
      recent_keys.delete(0);
  endtask

  // Field extremes, exact-match rules, expiry bounds, early stop and the
  // lifetime comparison near the top of the time range.
  task automatic test_directed_corners();
    // Default lifetime: all-zero and all-one keys, then near misses.
    send_key('0, '0, 8'h00, '0);
    send_key('0, '0, 8'h00, '0);
    send_key('1, '1, 8'hFF, '1);
    send_key('1, '1, 8'hFF, '1);
    send_key('1, '1, 8'hFE, '1);
    send_key(64'hFFFF_FFFF_FFFF_FFFE, '1, 8'hFF, '1);
    send_key('1, 64'h7FFF_FFFF_FFFF_FFFF, 8'hFF, '1);

    // Early stop: the hit on the first key must leave the later, expired
    // slot alone, so it is still found once the lifetime is raised.
    write_lifetime(32'd100);
    send_key(64'hA, 64'h1A, 8'h0A, 64'd1000);
    send_key(64'hB, 64'h1B, 8'h0B, 64'd0);
    send_key(64'hA, 64'h1A, 8'h0A, 64'd1050);
    write_lifetime(32'hFFFF_FFFF);
    send_key(64'hB, 64'h1B, 8'h0B, 64'd1050);

    // Zero lifetime: an entry survives only at its own insertion time.
    write_lifetime(32'd0);
    send_key(64'hC, 64'h1C, 8'h0C, 64'd5);
    send_key(64'hC, 64'h1C, 8'h0C, 64'd5);
    send_key(64'hC, 64'h1C, 8'h0C, 64'd6);

    // Insertion time plus lifetime overflows 64 bits but must not wrap.
    write_lifetime(32'd100);
    send_key(64'hE, 64'h1E, 8'h0E, 64'hFFFF_FFFF_FFFF_FFF5);
    send_key(64'hE, 64'h1E, 8'h0E, 64'hFFFF_FFFF_FFFF_FFFE);
    send_key(64'hE, 64'h1E, 8'h0E, '1);

    // Exactly at the lifetime is still live; one more is expired.
    send_key(64'hD, 64'h1D, 8'h0D, 64'd500);
    send_key(64'hD, 64'h1D, 8'h0D, 64'd600);
    send_key(64'hD, 64'h1D, 8'h0D, 64'd601);
  endtask

  // Overfill the table with long-lived keys whose insertion times tie often,
  // then look some of them up again to see which were evicted.
  task automatic test_full_table();
    item_t filled[$];
    item_t it;
    write_lifetime(32'hFFFF_FFFF);
    repeat (72) begin
      it = random_key();
      it.now_time = 64'h0000_1000_0000_0000 + $urandom_range(0, 15);
      filled.push_back(it);
      send_item(it);
    end
    repeat (36) begin
      it = filled[$urandom_range(0, filled.size() - 1)];
      it.now_time = 64'h0000_1000_0000_0000 + $urandom_range(0, 15);
      send_item(it);
    end
  endtask

  // One batch of traffic under one lifetime: repeats of recent keys, near
  // misses, fresh keys and a little noise with arbitrary times.
  task automatic run_batch(input life_regime_t regime);
    item_t       it;
    int          pick;
    logic [31:0] life;
    logic [31:0] step_max;
    case (regime)
      LIFE_SHORT: begin
        life = $urandom_range(20, 400);
        step_max = life / 8 + 1;
      end
      LIFE_DEFAULT: begin
        life = mdc_pkg::LIFETIME_RESET;
        step_max = 2000;
      end
      LIFE_FOREVER: begin
        life = 32'hFFFF_FFFF;
        step_max = 1000;
      end
      LIFE_ZERO: begin
        life = 32'd0;
        step_max = 2;
      end
      default: begin
        life = $urandom;
        step_max = $urandom;
        clock_ms = {$urandom, $urandom};
      end
    endcase
    write_lifetime(life);
    repeat (BATCH_ITEMS) begin
      pick = $urandom_range(0, 99);
      if (pick < 40 && recent_keys.size() != 0) begin
        it = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
      end else if (pick < 50 && recent_keys.size() != 0) begin
        it = recent_keys[$urandom_range(0, recent_keys.size() - 1)];
        case ($urandom_range(0, 2))
          0: it.sender ^= 64'd1 << $urandom_range(0, 63);
          1: it.msg_time ^= 64'd1 << $urandom_range(0, 63);
          default: it.msg_kind ^= 8'd1 << $urandom_range(0, 7);
        endcase
      end else begin
        it = random_key();
        remember_key(it);
      end
      if (pick >= 95) begin
        it.now_time = {$urandom, $urandom};
      end else begin
        it.now_time = clock_ms;
        clock_ms += $urandom_range(0, step_max);
      end
      send_item(it);
    end
  endtask

  task automatic test_random_traffic(input int phase, input int snd_pct, input int rcv_pct);
    in_idle_pct = snd_pct;
    out_idle_pct = rcv_pct;
    for (int b = 0; b < 4; b++)
      run_batch(life_regime_t'((phase * 4 + b) % 5));
  endtask

  initial begin
    rst = 1'b1;
    in_valid = 1'b0;
    sender = '0;
    msg_time = '0;
    msg_kind = '0;
    now_time = '0;
    out_ready = 1'b0;
    cfg_we = 1'b0;
    cfg_wdata = '0;
    in_idle_pct = 25;
    out_idle_pct = 64;
    error_count = 0;
    result_count = 0;
    stall_cycles = 0;
    life_ms = mdc_pkg::LIFETIME_RESET;
    clock_ms = {32'd0, $urandom};
    for (int i = 0; i < mdc_pkg::SLOT_COUNT; i++)
      slot_live[i] = 1'b0;
    repeat (3) @(posedge clk);
    @(negedge clk);
    rst <= 1'b0;

    test_directed_corners();
    test_full_table();
    test_random_traffic(0, 25, 64);
    test_random_traffic(1, 64, 25);
    test_random_traffic(2, 0, 0);

    // Let the last results drain, then allow a scan's worth of extra time
    // for any result that should not be there.
    @(negedge clk);
    in_valid <= 1'b0;
    while (pending_seen.size() != 0)
      @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
    error_count += pending_seen.size();
    if (error_count == 0) begin
      $display("tb_message_dedup_cache: clean");
    end else begin
      $display("tb_message_dedup_cache: errors");
    end
    $finish;
  end

endmodule

// ----- sim.f -----
+incdir+design
design/mdc_pkg.sv
design/mdc_ram.sv
design/mdc_front.sv
design/mdc_scan.sv
design/message_dedup_cache.sv
bench/tb_message_dedup_cache.sv
